### hw/rtl/rcgm_pkg.sv
// Shared types, pulse thresholds and register indexes for the RC gated motor PWM.
package rcgm_pkg;

    localparam int DUTY_W  = 16;
    localparam int PULSE_W = 12;
    localparam int OUT_W   = 10;
    localparam int LIMIT_W = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // RC pulse windows in microseconds.
    localparam logic [PULSE_W-1:0] PULSE_MIN_US  = 12'd900;
    localparam logic [PULSE_W-1:0] PULSE_MAX_US  = 12'd2100;
    localparam logic [PULSE_W-1:0] NEUTRAL_LO_US = 12'd1200;
    localparam logic [PULSE_W-1:0] NEUTRAL_HI_US = 12'd1800;
    localparam logic [PULSE_W-1:0] REV_CENTER_US = 12'd1500;

    // Reverse map divides by this span; the divide is a reciprocal multiply
    // with REV_SHIFT fraction bits, exact for every offset up to 600 us.
    localparam int REV_SPAN_US = 500;
    localparam int REV_SHIFT   = 19;
    localparam int REV_D_W     = 10;

    localparam logic [LIMIT_W-1:0] FAULT_COUNT_MAX = 4'd15;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_SAFETY_ENABLE = 1'b0;
    localparam cfg_index_t REG_FAULT_LIMIT   = 1'b1;

    typedef enum logic [1:0] {
        PULSE_INVALID,
        PULSE_NEUTRAL,
        PULSE_REVERSE,
        PULSE_FORWARD
    } pulse_class_t;

    typedef struct packed {
        logic               safety_enable;
        logic [LIMIT_W-1:0] fault_limit;
        pulse_class_t       pulse_class;
    } gate_ctrl_t;

    function automatic pulse_class_t classify_pulse(input logic [PULSE_W-1:0] p);
        pulse_class_t c;
        if (p < PULSE_MIN_US || p > PULSE_MAX_US)
            c = PULSE_INVALID;
        else if (p > NEUTRAL_LO_US && p < NEUTRAL_HI_US)
            c = PULSE_NEUTRAL;
        else if (p <= REV_CENTER_US)
            c = PULSE_REVERSE;
        else
            c = PULSE_FORWARD;
        return c;
    endfunction

endpackage

### hw/rtl/rcgm_map.sv
// Duty and reverse-pulse maps onto forward compare values, clamped to the drive range.
module rcgm_map
    import rcgm_pkg::*;
#(
    parameter int PWM_PERIOD_COUNTS = 960
)
(
    input  logic signed [DUTY_W-1:0]                      duty_cmd,
    input  logic [PULSE_W-1:0]                            rc_pulse_us,
    output logic [$clog2(PWM_PERIOD_COUNTS+1)-1:0]        duty_fwd,
    output logic [$clog2(PWM_PERIOD_COUNTS+1)-1:0]        rev_fwd
);

    localparam int CW       = $clog2(PWM_PERIOD_COUNTS + 1);
    localparam int FWD_MAX  = (PWM_PERIOD_COUNTS * 9) / 10;
    localparam int BWD_MAX  = PWM_PERIOD_COUNTS - FWD_MAX;
    localparam int STOP_VAL = (FWD_MAX + BWD_MAX) / 2;
    localparam int SPAN     = FWD_MAX - BWD_MAX;
    localparam int REV_K    = STOP_VAL - BWD_MAX;
    localparam logic [63:0] REV_RECIP =
        ((64'(REV_K)) << REV_SHIFT) / 64'(REV_SPAN_US) + 64'd1;
    localparam int RCW      = $clog2(REV_RECIP + 64'd1);
    localparam int EXT_W    = (RCW + REV_D_W > REV_SHIFT + CW) ? (RCW + REV_D_W)
                                                               : (REV_SHIFT + CW);

    logic [DUTY_W-1:0]    duty_off;
    logic [DUTY_W+CW-1:0] duty_prod;
    logic [REV_D_W-1:0]   rev_d;
    logic [EXT_W-1:0]     rev_prod;
    logic [CW-1:0]        rev_depth;

    // Offset binary: duty + 32768.
    assign duty_off  = {~duty_cmd[DUTY_W-1], duty_cmd[DUTY_W-2:0]};
    assign duty_prod = (DUTY_W+CW)'(duty_off) * (DUTY_W+CW)'(SPAN);
    // The product shifted down is below SPAN, so no clamp is needed here.
    assign duty_fwd  = CW'(BWD_MAX) + duty_prod[DUTY_W +: CW];

    // Only meaningful for pulses of 900 to 1200 us.
    assign rev_d     = REV_D_W'(REV_CENTER_US - rc_pulse_us);
    assign rev_prod  = EXT_W'(rev_d) * EXT_W'(REV_RECIP);
    assign rev_depth = rev_prod[REV_SHIFT +: CW];

    // A depth past the stop-to-minimum span lands on the lower clamp.
    always_comb
    begin
        if (rev_depth >= CW'(REV_K))
            rev_fwd = CW'(BWD_MAX);
        else
            rev_fwd = CW'(STOP_VAL) - rev_depth;
    end

endmodule

### hw/rtl/rcgm_gate.sv
// Safety gate: fault counting, hold and forced stop, and last compare tracking.
module rcgm_gate
    import rcgm_pkg::*;
#(
    parameter int PWM_PERIOD_COUNTS = 960
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  gate_ctrl_t                             ctrl,
    input  logic [$clog2(PWM_PERIOD_COUNTS+1)-1:0] duty_fwd,
    input  logic [$clog2(PWM_PERIOD_COUNTS+1)-1:0] rev_fwd,
    output logic [$clog2(PWM_PERIOD_COUNTS+1)-1:0] fwd,
    output logic                                   fault_stop
);

    localparam int CW       = $clog2(PWM_PERIOD_COUNTS + 1);
    localparam int FWD_MAX  = (PWM_PERIOD_COUNTS * 9) / 10;
    localparam int BWD_MAX  = PWM_PERIOD_COUNTS - FWD_MAX;
    localparam int STOP_VAL = (FWD_MAX + BWD_MAX) / 2;

    logic [LIMIT_W-1:0] fault_count_reg;
    logic [LIMIT_W-1:0] fault_count_next;
    logic [LIMIT_W-1:0] fault_count_inc;
    logic [CW-1:0]      last_compare_reg;

    assign fault_count_inc = (fault_count_reg == FAULT_COUNT_MAX) ? fault_count_reg
                                                                  : fault_count_reg + 1'b1;

    always_comb
    begin
        fault_count_next = fault_count_reg;
        fwd              = duty_fwd;
        fault_stop       = 1'b0;
        if (ctrl.safety_enable)
        begin
            unique case (ctrl.pulse_class)
                PULSE_INVALID:
                begin
                    fault_count_next = fault_count_inc;
                    if (fault_count_inc >= ctrl.fault_limit)
                    begin
                        fwd        = CW'(STOP_VAL);
                        fault_stop = 1'b1;
                    end
                    else
                    begin
                        fwd = last_compare_reg;
                    end
                end
                PULSE_NEUTRAL:
                begin
                    fault_count_next = '0;
                    fwd              = CW'(STOP_VAL);
                end
                PULSE_REVERSE:
                begin
                    fault_count_next = '0;
                    fwd              = rev_fwd;
                end
                PULSE_FORWARD:
                begin
                    fault_count_next = '0;
                    fwd              = duty_fwd;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_count_reg  <= '0;
            last_compare_reg <= CW'(STOP_VAL);
        end
        else if (step)
        begin
            fault_count_reg  <= fault_count_next;
            last_compare_reg <= fwd;
        end
    end

endmodule

### hw/rtl/rc_gated_motor_pwm.sv
// Top level of the RC gated H-bridge PWM compare generator.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, duty_cmd, rc_pulse_us | into block
//  out     | out_valid, out_ready, fwd_compare,        | out of block
//          | bwd_compare, fault_stop                   |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// One transaction is accepted per cycle while in_ready is high. An accepted
// transaction is first held in the input register, then the map multipliers and
// the gate logic feed the output register, which drives the outputs. The
// output register lets a new input transaction in while a result waits; in_ready
// drops only when both stages are full and out_ready is low. Reset clears the
// stages, the fault counter and sets the held compare to stop. Configuration
// writes are always ready.
module rc_gated_motor_pwm
    import rcgm_pkg::*;
#(
    parameter int PWM_PERIOD_COUNTS = 960
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DUTY_W-1:0] duty_cmd,
    input  logic [PULSE_W-1:0]       rc_pulse_us,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_W-1:0]         fwd_compare,
    output logic [OUT_W-1:0]         bwd_compare,
    output logic                     fault_stop,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW       = $clog2(PWM_PERIOD_COUNTS + 1);
    localparam int FWD_MAX  = (PWM_PERIOD_COUNTS * 9) / 10;
    localparam int BWD_MAX  = PWM_PERIOD_COUNTS - FWD_MAX;
    localparam int STOP_VAL = (FWD_MAX + BWD_MAX) / 2;
    localparam logic [OUT_W-1:0] PERIOD_LOW = OUT_W'(PWM_PERIOD_COUNTS);
    localparam logic [OUT_W-1:0] STOP_LOW   = OUT_W'(STOP_VAL);

    logic                     safety_enable_reg;
    logic [LIMIT_W-1:0]       fault_limit_reg;

    logic                     in_valid_reg;
    logic signed [DUTY_W-1:0] duty_reg;
    logic [PULSE_W-1:0]       pulse_reg;

    logic                     out_valid_reg;
    logic [OUT_W-1:0]         fwd_reg;
    logic [OUT_W-1:0]         bwd_reg;
    logic                     stop_reg;

    logic                     out_free;
    logic                     step;
    gate_ctrl_t               ctrl;
    logic [CW-1:0]            duty_fwd;
    logic [CW-1:0]            rev_fwd;
    logic [CW-1:0]            fwd;
    logic                     gate_stop;

    assign out_free  = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safety_enable_reg <= 1'b0;
            fault_limit_reg   <= 4'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAFETY_ENABLE: safety_enable_reg <= cfg_data[0];
                REG_FAULT_LIMIT:   fault_limit_reg   <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            duty_reg  <= duty_cmd;
            pulse_reg <= rc_pulse_us;
        end
        if (step)
        begin
            fwd_reg  <= OUT_W'(fwd);
            bwd_reg  <= PERIOD_LOW - OUT_W'(fwd);
            stop_reg <= gate_stop;
        end
    end

    assign ctrl.safety_enable = safety_enable_reg;
    assign ctrl.fault_limit   = fault_limit_reg;
    assign ctrl.pulse_class   = classify_pulse(pulse_reg);

    rcgm_map #(
        .PWM_PERIOD_COUNTS (PWM_PERIOD_COUNTS)
    ) u_map (
        .duty_cmd    (duty_reg),
        .rc_pulse_us (pulse_reg),
        .duty_fwd    (duty_fwd),
        .rev_fwd     (rev_fwd)
    );

    rcgm_gate #(
        .PWM_PERIOD_COUNTS (PWM_PERIOD_COUNTS)
    ) u_gate (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .ctrl       (ctrl),
        .duty_fwd   (duty_fwd),
        .rev_fwd    (rev_fwd),
        .fwd        (fwd),
        .fault_stop (gate_stop)
    );

    assign out_valid   = out_valid_reg;
    assign fwd_compare = fwd_reg;
    assign bwd_compare = bwd_reg;
    assign fault_stop  = stop_reg;

    // A forced stop always carries the stop compare.
    a_stop_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_stop |-> fwd_compare == STOP_LOW)
        else $error("forced stop without stop compare");

    // The two compares always add up to the period.
    a_complement: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> OUT_W'(fwd_compare + bwd_compare) == PERIOD_LOW)
        else $error("compares are not complementary");

    // The input side only stalls behind a stalled, full output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && in_valid_reg)
        else $error("input stalled without output back-pressure");

    // With the gate off, no forced stop can be produced.
    a_stop_needs_gate: assert property (@(posedge clk) disable iff (!rst_n)
        step && gate_stop |-> safety_enable_reg)
        else $error("forced stop while safety gating is off");

endmodule

### dv/rc_gated_motor_pwm_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RC gated H-bridge PWM compare generator.
module rc_gated_motor_pwm_test;
    import rcgm_pkg::*;

    localparam int PERIOD         = 960;
    localparam int FWD_MAX        = PERIOD * 9 / 10;
    localparam int BWD_MAX        = PERIOD - FWD_MAX;
    localparam int STOP_CMP       = (FWD_MAX + BWD_MAX) / 2;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 116;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [OUT_W-1:0] fwd;
        logic [OUT_W-1:0] bwd;
        logic             stop;
    } compare_pair_t;

    class compare_scoreboard;
        logic               gate_on;
        logic [LIMIT_W-1:0] stop_after;
        logic [LIMIT_W-1:0] bad_pulses;
        int unsigned        held_fwd;
        compare_pair_t      expected_q[$];
        int                 mismatches;

        function new();
            gate_on    = 1'b0;
            stop_after = 4'd3;
            bad_pulses = '0;
            held_fwd   = STOP_CMP;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SAFETY_ENABLE)
                gate_on = data[0];
            else
                stop_after = data[LIMIT_W-1:0];
        endfunction

        function int unsigned clamp_fwd(int unsigned v);
            if (v < BWD_MAX)
                return BWD_MAX;
            if (v > FWD_MAX)
                return FWD_MAX;
            return v;
        endfunction

        // Offset binary of the Q1.15 duty scaled onto the compare span, truncated.
        function int unsigned duty_to_fwd(logic signed [DUTY_W-1:0] duty);
            logic [DUTY_W-1:0] offset;
            int unsigned       offset_u;
            offset   = duty ^ 16'h8000;
            offset_u = offset;
            return BWD_MAX + ((offset_u * (FWD_MAX - BWD_MAX)) >> 16);
        endfunction

        function int unsigned pulse_to_reverse(logic [PULSE_W-1:0] pulse);
            int unsigned depth;
            depth = ((1500 - int'(pulse)) * (STOP_CMP - BWD_MAX)) / 500;
            if (depth > STOP_CMP)
                return 0;
            return STOP_CMP - depth;
        endfunction

        function pulse_class_t sort_pulse(logic [PULSE_W-1:0] pulse);
            if (pulse < 900 || pulse > 2100)
                return PULSE_INVALID;
            if (pulse > 1200 && pulse < 1800)
                return PULSE_NEUTRAL;
            if (pulse <= 1500)
                return PULSE_REVERSE;
            return PULSE_FORWARD;
        endfunction

        function void note_input(logic signed [DUTY_W-1:0] duty, logic [PULSE_W-1:0] pulse);
            int unsigned   fwd;
            int unsigned   bwd;
            compare_pair_t res;
            res.stop = 1'b0;
            if (!gate_on)
            begin
                fwd = clamp_fwd(duty_to_fwd(duty));
            end
            else
            begin
                case (sort_pulse(pulse))
                    PULSE_INVALID:
                    begin
                        if (bad_pulses != FAULT_COUNT_MAX)
                            bad_pulses = bad_pulses + 1'b1;
                        if (bad_pulses >= stop_after)
                        begin
                            fwd      = clamp_fwd(STOP_CMP);
                            res.stop = 1'b1;
                        end
                        else
                        begin
                            fwd = held_fwd;
                        end
                    end
                    PULSE_NEUTRAL:
                    begin
                        bad_pulses = '0;
                        fwd        = clamp_fwd(STOP_CMP);
                    end
                    PULSE_REVERSE:
                    begin
                        bad_pulses = '0;
                        fwd        = clamp_fwd(pulse_to_reverse(pulse));
                    end
                    default:
                    begin
                        bad_pulses = '0;
                        fwd        = clamp_fwd(duty_to_fwd(duty));
                    end
                endcase
            end
            held_fwd = fwd;
            bwd      = PERIOD - fwd;
            res.fwd  = fwd[OUT_W-1:0];
            res.bwd  = bwd[OUT_W-1:0];
            expected_q.push_back(res);
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        endtask

        task check_result(logic [OUT_W-1:0] fwd, logic [OUT_W-1:0] bwd, logic stop);
            compare_pair_t want;
            if (expected_q.size() == 0)
            begin
                report("result with no pending transaction, fwd_compare", fwd, 0);
                return;
            end
            want = expected_q.pop_front();
            if (fwd !== want.fwd)
                report("fwd_compare", fwd, want.fwd);
            if (bwd !== want.bwd)
                report("bwd_compare", bwd, want.bwd);
            if (stop !== want.stop)
                report("fault_stop", stop, want.stop);
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DUTY_W-1:0] duty_cmd = '0;
    logic [PULSE_W-1:0]       rc_pulse_us = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [OUT_W-1:0]         fwd_compare;
    logic [OUT_W-1:0]         bwd_compare;
    logic                     fault_stop;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index = REG_SAFETY_ENABLE;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    idle_mode_t               idle_mode = IDLE_NONE;
    int                       cycle_count = 0;
    compare_scoreboard        board = new();

    rc_gated_motor_pwm #(
        .PWM_PERIOD_COUNTS(PERIOD)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .duty_cmd(duty_cmd),
        .rc_pulse_us(rc_pulse_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .fwd_compare(fwd_compare),
        .bwd_compare(bwd_compare),
        .fault_stop(fault_stop),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (idle_mode == IDLE_RECEIVER)
            out_ready <= ($urandom_range(0, 99) >= 67);
        else if (idle_mode == IDLE_BOTH)
            out_ready <= ($urandom_range(0, 99) >= 7);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(fwd_compare, bwd_compare, fault_stop);
    end

    function automatic logic sender_pauses();
        if (idle_mode == IDLE_SENDER)
            return ($urandom_range(0, 99) < 67);
        if (idle_mode == IDLE_BOTH)
            return ($urandom_range(0, 99) < 7);
        return 1'b0;
    endfunction

    function automatic logic signed [DUTY_W-1:0] random_duty();
        logic [31:0] r;
        r = $urandom();
        if (r[31:28] == 4'h0)
            return 16'sh8000;
        if (r[31:28] == 4'h1)
            return 16'sh7FFF;
        return r[DUTY_W-1:0];
    endfunction

    // Pulse drawn from the window that the selector picks; the top 15 of 100 selector values span the full range.
    function automatic logic [PULSE_W-1:0] random_pulse(int unsigned sel);
        if (sel < 20)
            return PULSE_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 899)
                                                         : $urandom_range(2101, 4095));
        if (sel < 40)
            return PULSE_W'($urandom_range(1201, 1799));
        if (sel < 60)
            return PULSE_W'($urandom_range(900, 1200));
        if (sel < 85)
            return PULSE_W'($urandom_range(1800, 2100));
        return PULSE_W'($urandom_range(0, 4095));
    endfunction

    task automatic send_item(input logic signed [DUTY_W-1:0] duty,
                             input logic [PULSE_W-1:0] pulse);
        while (sender_pauses())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        duty_cmd    <= duty;
        rc_pulse_us <= pulse;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(duty, pulse);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic safety, input logic [LIMIT_W-1:0] limit);
        wait_drained();
        write_register(REG_SAFETY_ENABLE, {{(CFG_DATA_W-1){1'b0}}, safety});
        write_register(REG_FAULT_LIMIT, limit);
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] limit_table [RANDOM_PHASES];
        int                 phase_idx;
        int                 sent;
        int                 burst;
        int unsigned        sel;

        limit_table = '{4'd1, 4'd15, 4'd2, 4'd15, 4'd3, 4'd1, 4'd8, 4'd0};
        limit_table[RANDOM_PHASES-1] = LIMIT_W'($urandom_range(1, 15));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Safety off after reset: the pulse is ignored and the duty extremes map directly.
        send_item(16'sh8000, 12'd0);
        send_item(-16'sd1, 12'd4095);
        send_item(16'sd0, 12'd1500);
        send_item(16'sh7FFF, 12'd900);
        send_item(16'sd16384, 12'd2101);

        configure(1'b1, 4'd3);
        send_item(16'sh7FFF, 12'd2100);
        send_item(16'sh8000, 12'd1800);
        send_item(16'sd0, 12'd1799);
        send_item(16'sd0, 12'd1201);
        send_item(16'sd0, 12'd1200);
        send_item(16'sd0, 12'd900);
        // Invalid pulses hold the last compare until the third one forces a stop.
        send_item(16'sd0, 12'd899);
        send_item(16'sd0, 12'd2101);
        send_item(16'sd0, 12'd0);
        send_item(16'sd0, 12'd4095);
        send_item(16'sd0, 12'd1000);

        // A zero fault limit stops on the very first invalid pulse.
        configure(1'b1, 4'd0);
        send_item(16'sd0, 12'd1100);
        send_item(16'sd5000, 12'd3000);

        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            configure(phase_idx % 4 != 3, limit_table[phase_idx]);
            idle_mode <= idle_mode_t'(phase_idx % 4);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                sel   = $urandom_range(0, 99);
                // Runs of invalid pulses reach the fault limit and the counter ceiling.
                burst = (sel < 20) ? $urandom_range(1, 17) : 1;
                repeat (burst)
                    send_item(random_duty(), random_pulse(sel));
                sent += burst;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rcgm_pkg.sv
hw/rtl/rcgm_map.sv
hw/rtl/rcgm_gate.sv
hw/rtl/rc_gated_motor_pwm.sv
dv/rc_gated_motor_pwm_test.sv
